// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define FHP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When cause holds, effect must hold at the next clock edge.
`define FHP_ASSERT_NEXT(lbl, clk, rst, cause, effect, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error(msg);

`endif

// ===== rtl/fhp_pkg.sv =====
package fhp_pkg;

   localparam int DEFAULT_MAX_COMMAND_WORDS = 4;

   localparam logic [7:0] POS_SRC_IP = 8'd16;
   localparam logic [7:0] POS_DST_IP = 8'd20;
   localparam logic [7:0] POS_PORT   = 8'd24;
   localparam logic [7:0] POS_CMD    = 8'd26;
   localparam logic [7:0] POS_WORDS  = 8'd28;
   localparam logic [7:0] POS_SAT    = 8'd255;

   localparam logic [2:0] WORD_LAST_OFF = 3'd4;

   localparam logic [7:0] KEY_END    = 8'h00;
   localparam logic [7:0] KEY_SERIAL = 8'h01;
   localparam logic [7:0] KEY_TIME   = 8'h02;
   localparam logic [7:0] KEY_ROUTE  = 8'h3F;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] source_ip;
      logic [31:0] dest_ip;
      logic [15:0] dest_port;
      logic [15:0] command_code;
      logic [31:0] serial_number;
      logic [1:0]  instrument_type;
      logic [31:0] head_time;
      logic [31:0] route_ip;
   } rsp_type;

   // Replace byte lane of a little-endian word.
   function automatic logic [31:0] put_lane(input logic [31:0] word, input logic [1:0] lane,
                                            input logic [7:0] b);
      logic [31:0] res;
      res = word;
      res[lane*8 +: 8] = b;
      return res;
   endfunction

endpackage

// ===== rtl/frame_head_field_parser.sv =====
// Head frame field parser. Takes one frame byte per request (frame_byte plus
// a last_byte mark) and, on the last byte, returns one response carrying the
// little-endian header fields at bytes 16-27 and the values of up to
// MAX_COMMAND_WORDS 5-byte command words starting at byte 28 (key 0x01 serial
// number, 0x02 head time, 0x3F route IP; key 0x00 stops the scan; later
// duplicates win; missing fields read zero). The field registers update in the
// accept cycle and the response appears in the output register in the next
// cycle; one request per clock is sustained while req_stall stays low.
// A two-entry output stage (output register plus skid) sits behind the field
// logic; req_stall rises only when both entries hold undelivered responses.
module frame_head_field_parser
   import fhp_pkg::*;
#(
   parameter int MAX_COMMAND_WORDS = DEFAULT_MAX_COMMAND_WORDS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    req_take;     // request accepted this cycle
   logic    buf_full;     // both output entries occupied
   rsp_type fields;       // field values after this byte

   assign req_stall = buf_full;
   assign req_take  = req_valid && !buf_full;

   // Offset decode and field capture
   fhp_field_capture #(
      .MAX_COMMAND_WORDS(MAX_COMMAND_WORDS)
   ) u_capture (
      .clock  (clock),
      .reset  (reset),
      .take   (req_take),
      .req    (req_payload),
      .result (fields)
   );

   // Response register with skid so the input keeps moving under output stall
   fhp_out_buffer u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (req_take && req_payload.last_byte),
      .load_data   (fields),
      .full        (buf_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/fhp_field_capture.sv =====
`include "assert_macros.svh"

module fhp_field_capture
   import fhp_pkg::*;
#(
   parameter int MAX_COMMAND_WORDS = DEFAULT_MAX_COMMAND_WORDS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    take,
   input  req_type req,
   output rsp_type result
);

   localparam int IDX_W = $clog2(MAX_COMMAND_WORDS + 1);
   localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_COMMAND_WORDS);

   logic [7:0]       pos_ff, pos_in;
   logic [31:0]      src_ff, src_in, dst_ff, dst_in;
   logic [15:0]      port_ff, port_in, cmd_ff, cmd_in;
   logic [31:0]      serial_ff, serial_in, time_ff, time_in, route_ff, route_in;
   logic [31:0]      acc_ff, acc_in;
   logic [7:0]       key_ff, key_in;
   logic             ended_ff, ended_in;
   logic [2:0]       off_ff, off_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             clr;
   logic [31:0]      acc_new;
   logic             sat_hold;
   logic             frame_end;

   assign clr       = (pos_ff == 8'd0);
   assign sat_hold  = take && !req.last_byte && (pos_ff == POS_SAT);
   assign frame_end = take && req.last_byte;

   always_comb begin
      pos_in    = pos_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      port_in   = port_ff;
      cmd_in    = cmd_ff;
      serial_in = serial_ff;
      time_in   = time_ff;
      route_in  = route_ff;
      acc_in    = acc_ff;
      key_in    = key_ff;
      ended_in  = ended_ff;
      off_in    = off_ff;
      idx_in    = idx_ff;
      acc_new   = '0;
      if (take) begin
         // first byte of a frame wipes everything before use
         if (clr) begin
            src_in    = '0;
            dst_in    = '0;
            port_in   = '0;
            cmd_in    = '0;
            serial_in = '0;
            time_in   = '0;
            route_in  = '0;
            acc_in    = '0;
            key_in    = '0;
            ended_in  = 1'b0;
            off_in    = '0;
            idx_in    = '0;
         end
         acc_new = put_lane(acc_in, 2'(off_in - 3'd1), req.frame_byte);
         if (pos_ff != POS_SAT) begin
            if (pos_ff >= POS_SRC_IP && pos_ff < POS_DST_IP) begin
               src_in = put_lane(src_in, pos_ff[1:0], req.frame_byte);
            end else if (pos_ff >= POS_DST_IP && pos_ff < POS_PORT) begin
               dst_in = put_lane(dst_in, pos_ff[1:0], req.frame_byte);
            end else if (pos_ff >= POS_PORT && pos_ff < POS_CMD) begin
               port_in = 16'(put_lane({16'd0, port_in}, {1'b0, pos_ff[0]}, req.frame_byte));
            end else if (pos_ff >= POS_CMD && pos_ff < POS_WORDS) begin
               cmd_in = 16'(put_lane({16'd0, cmd_in}, {1'b0, pos_ff[0]}, req.frame_byte));
            end else if (pos_ff >= POS_WORDS) begin
               if (!ended_in && idx_in < MAX_IDX) begin
                  if (off_in == 3'd0) begin
                     key_in = req.frame_byte;
                     acc_in = '0;
                     if (req.frame_byte == KEY_END) begin
                        ended_in = 1'b1;
                     end
                  end else begin
                     acc_in = acc_new;
                     if (off_in == WORD_LAST_OFF) begin
                        if (key_in == KEY_SERIAL) begin
                           serial_in = acc_new;
                        end else if (key_in == KEY_TIME) begin
                           time_in = acc_new;
                        end else if (key_in == KEY_ROUTE) begin
                           route_in = acc_new;
                        end
                     end
                  end
               end
               // word offset / index track the byte position
               if (off_in == WORD_LAST_OFF) begin
                  off_in = '0;
                  if (idx_in != MAX_IDX) begin
                     idx_in = idx_in + 1'b1;
                  end
               end else begin
                  off_in = off_in + 3'd1;
               end
            end
            pos_in = pos_ff + 8'd1;
         end
         if (req.last_byte) begin
            pos_in = '0;
         end
      end
   end

   always_comb begin
      result.source_ip       = src_in;
      result.dest_ip         = dst_in;
      result.dest_port       = port_in;
      result.command_code    = cmd_in;
      result.serial_number   = serial_in;
      result.instrument_type = serial_in[1:0];
      result.head_time       = time_in;
      result.route_ip        = route_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         src_ff    <= '0;
         dst_ff    <= '0;
         port_ff   <= '0;
         cmd_ff    <= '0;
         serial_ff <= '0;
         time_ff   <= '0;
         route_ff  <= '0;
         acc_ff    <= '0;
         key_ff    <= '0;
         ended_ff  <= 1'b0;
         off_ff    <= '0;
         idx_ff    <= '0;
      end else begin
         pos_ff    <= pos_in;
         src_ff    <= src_in;
         dst_ff    <= dst_in;
         port_ff   <= port_in;
         cmd_ff    <= cmd_in;
         serial_ff <= serial_in;
         time_ff   <= time_in;
         route_ff  <= route_in;
         acc_ff    <= acc_in;
         key_ff    <= key_in;
         ended_ff  <= ended_in;
         off_ff    <= off_in;
         idx_ff    <= idx_in;
      end
   end

   `FHP_ASSERT(a_off_range, clock, reset, off_ff <= WORD_LAST_OFF, "word offset out of range")
   `FHP_ASSERT_NEXT(a_pos_sat, clock, reset, sat_hold, pos_ff == POS_SAT, "position left saturation")
   `FHP_ASSERT_NEXT(a_pos_wrap, clock, reset, frame_end, pos_ff == 8'd0, "position not cleared")

endmodule

// ===== rtl/fhp_out_buffer.sv =====
`include "assert_macros.svh"

module fhp_out_buffer
   import fhp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    take;
   logic    type_ok;

   assign take    = out_valid_ff && !rsp_stall;
   assign type_ok = (out_ff.instrument_type == out_ff.serial_number[1:0]);

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (load) begin
         if (!out_valid_ff || take) begin
            out_in       = load_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = load_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full        = skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   `FHP_ASSERT(a_skid_order, clock, reset, !skid_valid_ff || out_valid_ff, "skid ahead of output")
   `FHP_ASSERT_NEXT(a_skid_drain, clock, reset, skid_valid_ff && !rsp_stall, out_valid_ff, "skid lost")
   `FHP_ASSERT(a_type_bits, clock, reset, !out_valid_ff || type_ok, "instrument type mismatch")

endmodule

// ===== test/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fhp_pkg::*;

   localparam int CMD_WORDS  = DEFAULT_MAX_COMMAND_WORDS;
   localparam int WORD_LEN   = int'(WORD_LAST_OFF) + 1;   // key byte + 4 value bytes
   localparam int FULL_FRAME = int'(POS_WORDS) + CMD_WORDS * WORD_LEN;
   localparam int ITEM_GOAL  = 1850;
   localparam int CYCLE_CAP  = 400000;
   localparam int TAIL_WAIT  = 20;

   // ------------------------------------------------------------------
   // Field predictor and response checker.
   // Mirrors the parser: position counter, captured header fields and the
   // command-word scan. Each request with last_byte set queues one
   // expected response.
   // ------------------------------------------------------------------
   class frame_field_board;
      logic [7:0]  frame_pos;
      rsp_type     fields;
      logic [31:0] word_acc;
      logic [7:0]  word_key;
      bit          scan_done;
      rsp_type     fields_q[$];
      int          errors;

      function new();
         frame_pos = '0;
         errors    = 0;
         clear_fields();
      endfunction

      function void clear_fields();
         fields    = '0;
         word_acc  = '0;
         word_key  = '0;
         scan_done = 1'b0;
      endfunction

      // rel: offset from the start of the command-word area
      function void take_word_byte(int rel, logic [7:0] b);
         int idx;
         int off;
         idx = rel / WORD_LEN;
         off = rel % WORD_LEN;
         if (scan_done || idx >= CMD_WORDS) return;
         if (off == 0) begin
            word_key = b;
            word_acc = '0;
            if (b == KEY_END) scan_done = 1'b1;
         end else begin
            word_acc[(off - 1) * 8 +: 8] = b;
            // commit only once the fourth value byte is in
            if (off == int'(WORD_LAST_OFF)) begin
               case (word_key)
                  KEY_SERIAL: fields.serial_number = word_acc;
                  KEY_TIME:   fields.head_time     = word_acc;
                  KEY_ROUTE:  fields.route_ip      = word_acc;
                  default: ;
               endcase
            end
         end
      endfunction

      function void note_byte(req_type r);
         int      pos;
         rsp_type out;
         pos = int'(frame_pos);
         if (pos == 0) clear_fields();
         if (frame_pos != POS_SAT) begin
            if (pos >= int'(POS_SRC_IP) && pos < int'(POS_SRC_IP) + 4)
               fields.source_ip[(pos - int'(POS_SRC_IP)) * 8 +: 8] = r.frame_byte;
            else if (pos >= int'(POS_DST_IP) && pos < int'(POS_DST_IP) + 4)
               fields.dest_ip[(pos - int'(POS_DST_IP)) * 8 +: 8] = r.frame_byte;
            else if (pos >= int'(POS_PORT) && pos < int'(POS_PORT) + 2)
               fields.dest_port[(pos - int'(POS_PORT)) * 8 +: 8] = r.frame_byte;
            else if (pos >= int'(POS_CMD) && pos < int'(POS_CMD) + 2)
               fields.command_code[(pos - int'(POS_CMD)) * 8 +: 8] = r.frame_byte;
            else if (pos >= int'(POS_WORDS))
               take_word_byte(pos - int'(POS_WORDS), r.frame_byte);
            frame_pos = frame_pos + 8'd1;
         end
         if (r.last_byte) begin
            out = fields;
            out.instrument_type = fields.serial_number[1:0];
            fields_q.push_back(out);
            frame_pos = '0;
         end
      endfunction

      function void compare(string label, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
         end
      endfunction

      function void check_fields(rsp_type got);
         rsp_type want;
         if (fields_q.size() == 0) begin
            errors++;
            $display("%0t: response with nothing expected, got %p", $time, got);
            return;
         end
         want = fields_q.pop_front();
         compare("source_ip",       want.source_ip,       got.source_ip);
         compare("dest_ip",         want.dest_ip,         got.dest_ip);
         compare("dest_port",       want.dest_port,       got.dest_port);
         compare("command_code",    want.command_code,    got.command_code);
         compare("serial_number",   want.serial_number,   got.serial_number);
         compare("instrument_type", want.instrument_type, got.instrument_type);
         compare("head_time",       want.head_time,       got.head_time);
         compare("route_ip",        want.route_ip,        got.route_ip);
      endfunction

      function int pending();
         return fields_q.size();
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset and DUT
   // ------------------------------------------------------------------
   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   frame_head_field_parser #(.MAX_COMMAND_WORDS(CMD_WORDS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   frame_field_board board;

   int sender_idle_pct = 0;   // chance of an idle cycle before each request
   int rsp_stall_pct   = 0;   // chance of stalling the response side per cycle
   int items_sent      = 0;
   int cycles          = 0;

   logic [7:0] frame_q[$];    // bytes of the frame being built

   // ------------------------------------------------------------------
   // Monitor: sample both handshakes at the edge. Values read here are the
   // pre-edge values since all drivers use nonblocking updates.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_byte(req_payload);
         if (rsp_valid && !rsp_stall) board.check_fields(rsp_payload);
      end
   end

   // response-side backpressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_CAP) begin
         $display("%0t: timeout, %0d responses still expected", $time, board.pending());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Request driving and frame building
   // ------------------------------------------------------------------

   // Present one request, with optional idle cycles first, and hold it
   // until accepted. Valid is left high; the next call decides whether to
   // drop it.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{frame_byte: b, last_byte: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++)
         send_byte(frame_q[i], i == frame_q.size() - 1);
   endtask

   // header bytes 0..27: random or a fixed fill
   function automatic void start_frame(bit rand_hdr, logic [7:0] fill);
      frame_q.delete();
      for (int i = 0; i < int'(POS_WORDS); i++)
         frame_q.push_back(rand_hdr ? 8'($urandom_range(0, 255)) : fill);
   endfunction

   function automatic void add_word(logic [7:0] key, logic [31:0] value);
      frame_q.push_back(key);
      for (int i = 0; i < 4; i++) frame_q.push_back(value[i * 8 +: 8]);
   endfunction

   function automatic void add_random(int n);
      for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom_range(0, 255)));
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      int         frame_no;
      int         len;
      int         end_pct;
      int         pick;
      bit         noise;
      logic [7:0] b;

      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- directed frames ---

      // all-ones header, every known key plus an unknown one
      start_frame(1'b0, 8'hFF);
      add_word(KEY_SERIAL, 32'hFFFF_FFFF);
      add_word(KEY_TIME,   32'hFFFF_FFFF);
      add_word(KEY_ROUTE,  32'hFFFF_FFFF);
      add_word(8'hFF,      32'hFFFF_FFFF);
      send_frame();

      // all-zero header, end key first: the later serial word is ignored
      start_frame(1'b0, 8'h00);
      add_word(KEY_END,    32'h0);
      add_word(KEY_SERIAL, 32'h1234_5677);
      send_frame();

      // one-byte frame: nothing captured, everything reads zero
      frame_q.delete();
      frame_q.push_back(8'hA5);
      send_frame();

      // duplicate key overwrites, unknown key skipped, fifth word ignored
      start_frame(1'b1, 8'h00);
      add_word(KEY_SERIAL, $urandom());
      add_word(KEY_SERIAL, $urandom());
      add_word(8'h7E,      $urandom());
      add_word(KEY_ROUTE,  $urandom());
      add_word(KEY_TIME,   $urandom());
      send_frame();

      // end key in the middle of the scan
      start_frame(1'b1, 8'h00);
      add_word(KEY_SERIAL, $urandom());
      add_word(KEY_END,    $urandom());
      add_word(KEY_TIME,   $urandom());
      add_word(KEY_ROUTE,  $urandom());
      send_frame();

      // word cut off before its last value byte: not committed
      start_frame(1'b1, 8'h00);
      add_word(KEY_TIME, $urandom());
      frame_q.push_back(KEY_ROUTE);
      add_random(2);
      send_frame();

      // frame ends inside the destination IP
      frame_q.delete();
      add_random(22);
      send_frame();

      // long frame: position saturates, trailing bytes ignored
      start_frame(1'b1, 8'h00);
      add_word(KEY_ROUTE,  $urandom());
      add_word(KEY_SERIAL, $urandom());
      add_word(KEY_TIME,   $urandom());
      add_word(8'h03,      $urandom());
      add_random(300 - frame_q.size());
      send_frame();

      // --- random frames ---
      // Mostly well-formed frames with keys biased to the known ones; some
      // short, a few long, some pure noise. Idle/stall pattern rotates
      // every five frames.
      frame_no = 0;
      while (items_sent < ITEM_GOAL) begin
         case ((frame_no / 5) % 4)
            0:       begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin sender_idle_pct = 64; rsp_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  rsp_stall_pct = 64; end
            default: begin sender_idle_pct = 18; rsp_stall_pct = 18; end
         endcase

         // every so often hold off until the parser has fully drained;
         // valid drops first so the monitor has logged the last byte
         if (frame_no % 9 == 8) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (board.pending() != 0) @(posedge clock);
         end

         pick = $urandom_range(0, 99);
         if (pick < 12)      len = $urandom_range(1, FULL_FRAME - 1);
         else if (pick < 15) len = $urandom_range(256, 300);
         else                len = FULL_FRAME + $urandom_range(0, 4);
         noise   = ($urandom_range(0, 9) == 0);
         end_pct = ($urandom_range(0, 3) == 0) ? 15 : 2;

         frame_q.delete();
         for (int k = 0; k < len; k++) begin
            b = 8'($urandom_range(0, 255));
            if (!noise && k >= int'(POS_WORDS) && (k - int'(POS_WORDS)) % WORD_LEN == 0) begin
               pick = $urandom_range(0, 99);
               if (pick < end_pct) b = KEY_END;
               else if (pick < 35) b = KEY_SERIAL;
               else if (pick < 60) b = KEY_TIME;
               else if (pick < 85) b = KEY_ROUTE;
            end
            frame_q.push_back(b);
         end
         send_frame();
         frame_no++;
      end

      // drain and let any stray response show up
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      if (board.errors == 0 && board.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
